// ----- sv/assert_macros.svh -----
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- sv/mvsm_pkg.sv -----
// ----------------------------------------------------------------------------
// mvsm_pkg
// shared types and codes of the voice sample mixer
// ----------------------------------------------------------------------------
`default_nettype none
package mvsm_pkg;
   localparam logic [2:0] REQ_LOAD   = 3'd0;
   localparam logic [2:0] REQ_START  = 3'd1;
   localparam logic [2:0] REQ_PAUSE  = 3'd2;
   localparam logic [2:0] REQ_REMOVE = 3'd3;
   localparam logic [2:0] REQ_TICK   = 3'd4;

   // sample store depth, one word per 16-bit address
   localparam int SAMPLE_WORDS = 65536;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request fields, clear accumulator
      logic do_load;   // write sample store
      logic do_start;  // claim free slot
      logic do_pause;  // apply pause to matching slots
      logic do_remove; // free matching slots
      logic clr_slot;  // restart voice walk at slot 0
      logic rd_voice;  // issue sample read for current slot
      logic mix_voice; // mix and update current slot
      logic next_slot; // advance slot index
      logic respond;   // drive result strobe
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [2:0] req_code;
      logic       last_slot;
   } stat_type;
endpackage
`default_nettype wire

// ----- sv/mvsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// mvsm_ctrl
// sequencer: decode, slot walk for ticks, single-cycle result
// ----------------------------------------------------------------------------
`default_nettype none
module mvsm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output mvsm_pkg::cmd_type      cmd,
   input  wire mvsm_pkg::stat_type stat
);
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EXEC = 6'b000010,
      ST_READ = 6'b000100,
      ST_MIX  = 6'b001000,
      ST_RESP = 6'b010000,
      ST_WAIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (stat.req_code)
               mvsm_pkg::REQ_LOAD:   cmd.do_load = 1'b1;
               mvsm_pkg::REQ_START:  cmd.do_start = 1'b1;
               mvsm_pkg::REQ_PAUSE:  cmd.do_pause = 1'b1;
               mvsm_pkg::REQ_REMOVE: cmd.do_remove = 1'b1;
               default: ;
            endcase
            cmd.clr_slot = 1'b1;
            state_in = (stat.req_code == mvsm_pkg::REQ_TICK) ? ST_READ : ST_RESP;
         end
         ST_READ: begin
            cmd.rd_voice = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix_voice = 1'b1;
            cmd.next_slot = 1'b1;
            state_in = stat.last_slot ? ST_RESP : ST_READ;
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ----- sv/mvsm_data.sv -----
// ----------------------------------------------------------------------------
// mvsm_data
// sample store, voice slots and the one-multiplier mixer
// ----------------------------------------------------------------------------
`default_nettype none
module mvsm_data #(
   parameter int VOICES       = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mvsm_pkg::cmd_type  cmd,
   output mvsm_pkg::stat_type      stat,
   input  wire logic [2:0]         req_type,
   input  wire logic [15:0]        req_address,
   input  wire logic signed [15:0] req_sample_value,
   input  wire logic [16:0]        req_voice_len,
   input  wire logic               req_loop_on,
   input  wire logic               req_pause_on,
   output logic                    rsp_strobe,
   output logic                    rsp_is_sample,
   output logic signed [15:0]      rsp_mixed_sample,
   output logic                    rsp_start_dropped,
   output logic [3:0]              rsp_active_voices
);
   localparam int AW = $clog2(mvsm_pkg::SAMPLE_WORDS);
   localparam int SW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CW = $clog2(VOICES + 1);

   logic signed [15:0] mem [mvsm_pkg::SAMPLE_WORDS];
   logic signed [15:0] rd_ff;

   logic [2:0]  code_ff;
   logic [15:0] addr_ff;
   logic signed [15:0] val_ff;
   logic [16:0] len_ff;
   logic loop_ff, pause_ff;

   logic [VOICES-1:0] use_ff, use_in, paus_ff, paus_in, lp_ff, lp_in;
   logic [15:0] base_ff [VOICES];
   logic [16:0] slen_ff [VOICES];
   logic [16:0] pos_ff  [VOICES];
   logic [16:0] pos_in  [VOICES];
   logic [15:0] base_in [VOICES];
   logic [16:0] slen_in [VOICES];

   logic [SW-1:0] slot_ff;
   logic signed [15:0] acc_ff;
   logic signed [15:0] acc_in;
   logic drop_ff, drop_in;
   logic play_ff;

   logic          free_found;
   logic [SW-1:0] free_idx;
   logic [CW-1:0] cnt;

   logic signed [31:0] prod;
   logic signed [31:0] quot;
   logic signed [17:0] sum;

   assign stat.req_code  = code_ff;
   assign stat.last_slot = (32'(slot_ff) == VOICES - 1);

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (!use_ff[i]) begin
            free_found = 1'b1;
            free_idx = SW'(i);
         end
      end
   end

   always_comb begin
      cnt = '0;
      for (int i = 0; i < VOICES; i++) cnt = cnt + CW'(use_ff[i]);
   end

   // mix step: acc + s - trunc(acc*s / 32768), saturated
   always_comb begin
      prod = acc_ff * rd_ff;
      quot = (prod < 0) ? -((-prod) >>> 15) : (prod >>> 15);
      sum  = 18'(acc_ff) + 18'(rd_ff) - 18'(quot);
      if (sum > 18'sd32767)       acc_in = 16'sh7fff;
      else if (sum < -18'sd32768) acc_in = 16'sh8000;
      else                        acc_in = sum[15:0];
   end

   always_comb begin
      use_in = use_ff; paus_in = paus_ff; lp_in = lp_ff;
      drop_in = drop_ff;
      for (int i = 0; i < VOICES; i++) begin
         pos_in[i] = pos_ff[i];
         base_in[i] = base_ff[i];
         slen_in[i] = slen_ff[i];
      end
      if (cmd.do_start) begin
         if (free_found) begin
            use_in[free_idx] = 1'b1;
            base_in[free_idx] = addr_ff;
            slen_in[free_idx] = len_ff;
            pos_in[free_idx] = '0;
            lp_in[free_idx] = loop_ff;
            paus_in[free_idx] = 1'b0;
         end else drop_in = 1'b1;
      end
      for (int i = 0; i < VOICES; i++) begin
         if (cmd.do_pause && use_ff[i] && base_ff[i] == addr_ff) paus_in[i] = pause_ff;
         if (cmd.do_remove && use_ff[i] && base_ff[i] == addr_ff) use_in[i] = 1'b0;
      end
      if (cmd.mix_voice && use_ff[slot_ff] && !paus_ff[slot_ff]) begin
         if (play_ff) begin
            if (pos_ff[slot_ff] + 17'd1 >= slen_ff[slot_ff]) begin
               if (lp_ff[slot_ff]) pos_in[slot_ff] = '0;
               else use_in[slot_ff] = 1'b0;
            end else pos_in[slot_ff] = pos_ff[slot_ff] + 17'd1;
         end else use_in[slot_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         code_ff <= req_type; addr_ff <= req_address; val_ff <= req_sample_value;
         len_ff <= req_voice_len; loop_ff <= req_loop_on; pause_ff <= req_pause_on;
      end
      if (cmd.do_load) mem[addr_ff[AW-1:0]] <= val_ff;
      if (cmd.rd_voice) begin
         rd_ff <= mem[AW'(base_ff[slot_ff] + pos_ff[slot_ff][15:0])];
         play_ff <= pos_ff[slot_ff] < slen_ff[slot_ff];
      end
      for (int i = 0; i < VOICES; i++) begin
         pos_ff[i] <= pos_in[i]; base_ff[i] <= base_in[i]; slen_ff[i] <= slen_in[i];
      end
      paus_ff <= paus_in; lp_ff <= lp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_ff <= '0; slot_ff <= '0; acc_ff <= '0; drop_ff <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         use_ff <= use_in;
         drop_ff <= cmd.capture ? 1'b0 : drop_in;
         if (cmd.capture) acc_ff <= '0;
         else if (cmd.mix_voice && use_ff[slot_ff] && !paus_ff[slot_ff] && play_ff)
            acc_ff <= acc_in;
         if (cmd.clr_slot) slot_ff <= '0;
         else if (cmd.next_slot) slot_ff <= slot_ff + SW'(1);
         rsp_strobe <= cmd.respond;
         if (cmd.respond) begin
            rsp_is_sample <= (code_ff == mvsm_pkg::REQ_TICK);
            rsp_mixed_sample <= acc_ff;
            rsp_start_dropped <= drop_ff;
            rsp_active_voices <= (32'(cnt) > 15) ? 4'd15 : 4'(cnt);
         end
      end
   end
endmodule
`default_nettype wire

// ----- sv/multi_voice_sample_mixer.sv -----
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// pcm voice mixer with on-chip sample store and voice slot table
// ----------------------------------------------------------------------------
// channel   | ports           | handshake
// request   | start, req_*    | taken when start is high and busy is low
// response  | rsp_*           | rsp_strobe high one cycle, no back-pressure
//
// a non-tick request keeps busy high after its accept edge through the execute,
// respond and wait states, so no new request is taken until it has finished;
// a tick keeps busy high through execute, then for each slot a memory read
// and a mix step through the single multiplier, then respond and wait, and no
// new request is taken meanwhile; the strobe sits in the last busy cycle
// reset is synchronous, clears the slot in-use bits and the sequencer
// the sample store is not cleared; unloaded words read as garbage
`default_nettype none
`include "assert_macros.svh"
module multi_voice_sample_mixer #(
   parameter int VOICES       = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_type,
   input  wire logic [15:0]        req_address,
   input  wire logic signed [15:0] req_sample_value,
   input  wire logic [16:0]        req_voice_len,
   input  wire logic               req_loop_on,
   input  wire logic               req_pause_on,
   output logic                    rsp_strobe,
   output logic                    rsp_is_sample,
   output logic signed [15:0]      rsp_mixed_sample,
   output logic                    rsp_start_dropped,
   output logic [3:0]              rsp_active_voices
);
   mvsm_pkg::cmd_type  cmd;
   mvsm_pkg::stat_type stat;

   // sequencer
   mvsm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .cmd(cmd), .stat(stat)
   );

   // storage and mixing
   mvsm_data #(.VOICES(VOICES)) u_data (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_type(req_type), .req_address(req_address),
      .req_sample_value(req_sample_value), .req_voice_len(req_voice_len),
      .req_loop_on(req_loop_on), .req_pause_on(req_pause_on),
      .rsp_strobe(rsp_strobe), .rsp_is_sample(rsp_is_sample),
      .rsp_mixed_sample(rsp_mixed_sample), .rsp_start_dropped(rsp_start_dropped),
      .rsp_active_voices(rsp_active_voices)
   );

   // a response only comes while a request is in flight
   `ASSERT_IMPLY(a_rsp_busy, clock, reset, rsp_strobe, busy, "response while idle")
   // response strobe is a single pulse
   `ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_strobe, !rsp_strobe, "double response")
   // an accepted request makes the block busy
   `ASSERT_NEXT(a_accept, clock, reset, start && !busy, busy, "accept not seen")
   // drop flag only on non-tick results
   `ASSERT_IMPLY(a_drop, clock, reset, rsp_strobe && rsp_start_dropped, !rsp_is_sample,
      "drop on tick")
endmodule
`default_nettype wire
